[sv/itra_pkg.sv]
// ----------------------------------------------------------------------------
// itra_pkg
// Shared types, character codes and the digit-to-ASCII function for the
// integer to radix ASCII converter.
// ----------------------------------------------------------------------------
package itra_pkg;

  localparam logic [6:0] CHAR_NUL   = 7'h00;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h61;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  typedef struct packed {
    logic load;
    logic shift;
    logic emit_sign;
    logic emit_digit;
    logic emit_error;
  } itra_cmd_t;

  typedef struct packed {
    logic radix_bad;
    logic neg;
    logic last_bit;
    logic last_digit;
  } itra_status_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_A + {3'b000, d - 4'd10};
    end
    return c;
  endfunction

endpackage

[sv/itra_datapath.sv]
// ----------------------------------------------------------------------------
// itra_datapath
// Magnitude shifter, radix digit array with its carry add, and the
// registered character outputs.
// ----------------------------------------------------------------------------
module itra_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [VALUE_WIDTH-1:0]    value,
  input  logic                      is_signed,
  input  logic [4:0]                radix,
  input  itra_pkg::itra_cmd_t       cmd,
  output itra_pkg::itra_status_t    status,
  output logic                      strobe,
  output logic [6:0]                character,
  output logic                      last_char,
  output logic                      radix_error
);

  localparam int VW   = VALUE_WIDTH;
  localparam int IDXW = $clog2(VW);
  localparam int NCW  = $clog2(VW + 1);

  logic [VW-1:0]   mag;
  logic            neg;
  logic [4:0]      rad;
  logic [3:0]      digits [VW];
  logic [3:0]      digits_next [VW];
  logic [4:0]      sub_val [VW];
  logic [NCW-1:0]  ndig;
  logic [NCW-1:0]  ndig_m1;
  logic [IDXW-1:0] rd_idx;
  logic [IDXW-1:0] bitcnt;
  logic [VW-1:0]   gen;
  logic [VW-1:0]   prop;
  logic [VW:0]     sum;
  logic [VW:0]     carry;
  logic            in_neg;

  assign in_neg = is_signed & value[VW-1];

  always_comb begin
    for (int i = 0; i < VW; i++) begin
      gen[i]  = {digits[i], 1'b0} >= rad;
      prop[i] = {digits[i], 1'b0} == (rad - 5'd1);
    end
    sum   = {1'b0, gen | prop} + {1'b0, gen} + {{VW{1'b0}}, mag[VW-1]};
    carry = sum ^ {1'b0, (gen | prop) ^ gen};
    for (int i = 0; i < VW; i++) begin
      sub_val[i]     = {digits[i], carry[i]} - (carry[i+1] ? rad : 5'd0);
      digits_next[i] = sub_val[i][3:0];
    end
  end

  assign ndig_m1 = ndig - NCW'(1);
  assign rd_idx  = ndig_m1[IDXW-1:0];

  assign status.radix_bad  = (radix < itra_pkg::RADIX_MIN) || (radix > itra_pkg::RADIX_MAX);
  assign status.neg        = neg;
  assign status.last_bit   = bitcnt == IDXW'(VW - 1);
  assign status.last_digit = ndig == NCW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag    <= in_neg ? (~value + VW'(1)) : value;
      neg    <= in_neg;
      rad    <= radix;
      ndig   <= NCW'(1);
      bitcnt <= '0;
      for (int i = 0; i < VW; i++) begin
        digits[i] <= 4'd0;
      end
    end else if (cmd.shift) begin
      mag    <= {mag[VW-2:0], 1'b0};
      bitcnt <= bitcnt + IDXW'(1);
      if (carry[ndig]) begin
        ndig <= ndig + NCW'(1);
      end
      for (int i = 0; i < VW; i++) begin
        digits[i] <= digits_next[i];
      end
    end else if (cmd.emit_digit) begin
      ndig <= ndig_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign | cmd.emit_digit | cmd.emit_error;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_error) begin
      character   <= itra_pkg::CHAR_NUL;
      last_char   <= 1'b1;
      radix_error <= 1'b1;
    end else if (cmd.emit_sign) begin
      character   <= itra_pkg::CHAR_MINUS;
      last_char   <= 1'b0;
      radix_error <= 1'b0;
    end else if (cmd.emit_digit) begin
      character   <= itra_pkg::digit_char(digits[rd_idx]);
      last_char   <= status.last_digit;
      radix_error <= 1'b0;
    end
  end

endmodule

[sv/itra_controller.sv]
// ----------------------------------------------------------------------------
// itra_controller
// Sequencer for one conversion: load, bit shifts, sign, digits or radix error.
// ----------------------------------------------------------------------------
module itra_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  itra_pkg::itra_status_t status,
  output itra_pkg::itra_cmd_t    cmd,
  output logic                   busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (status.radix_bad) begin
            cmd.emit_error = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_CONV;
          end
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        if (status.last_bit) begin
          state_next = status.neg ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (status.last_digit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/integer_to_radix_ascii.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a binary number into its ASCII text in a radix from 2 to 16,
// most significant digit first, one character per output strobe.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// input     in         start high, busy low    value, is_signed, radix
// result    out        strobe, one cycle       character, last_char, radix_error
//
// A conversion loads the operands, shifts the magnitude into the radix digit
// array one bit per cycle through a single carry add across all digits, then
// gives an optional minus sign and the digits, most significant first.
// A bad radix gives one error result.
// Reset is synchronous and returns the sequencer to idle with no strobe.
// Results cannot be stalled; each is valid only in its strobe cycle.
module integer_to_radix_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   is_signed,
  input  logic [4:0]             radix,
  output logic                   strobe,
  output logic [6:0]             character,
  output logic                   last_char,
  output logic                   radix_error
);

  itra_pkg::itra_cmd_t    cmd;
  itra_pkg::itra_status_t status;

  itra_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  itra_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .is_signed   (is_signed),
    .radix       (radix),
    .cmd         (cmd),
    .status      (status),
    .strobe      (strobe),
    .character   (character),
    .last_char   (last_char),
    .radix_error (radix_error)
  );

endmodule

[sv/itra_checker.sv]
// ----------------------------------------------------------------------------
// itra_checker
// Port-level checks of the converter's transaction sequencing.
// ----------------------------------------------------------------------------
module itra_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [4:0] radix,
  input logic       strobe,
  input logic [6:0] character,
  input logic       last_char,
  input logic       radix_error
);

  logic accepted;
  logic bad_radix;

  assign accepted  = start && !busy;
  assign bad_radix = (radix < 5'd2) || (radix > 5'd16);

  a_chars_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_char |=> strobe)
    else $error("characters of one transaction are not back to back");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    strobe && radix_error |-> last_char && character == 7'd0)
    else $error("error result is not a single zero character");

  a_bad_radix_reply: assert property (@(posedge clk) disable iff (rst)
    accepted && bad_radix |=> strobe && radix_error && !busy)
    else $error("bad radix did not give one error result");

  a_good_radix_busy: assert property (@(posedge clk) disable iff (rst)
    accepted && !bad_radix |=> busy && !strobe)
    else $error("valid transaction did not start a conversion");

  a_busy_mid_text: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_char |-> busy)
    else $error("converter went idle before the last character");

endmodule

bind integer_to_radix_ascii itra_checker u_itra_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .radix       (radix),
  .strobe      (strobe),
  .character   (character),
  .last_char   (last_char),
  .radix_error (radix_error)
);
